[design/sds_pkg.sv]
// ----------------------------------------------------------------------------
// sds_pkg: shared types and constants for the SCAN disk scheduler
// Holds the channel beat types, queue and row control types, register
// indexes and the controller state type used across the scheduler files.
// ----------------------------------------------------------------------------
package sds_pkg;

  // Default batch capacity in requests.
  localparam int MAX_REQUESTS = 32;

  // Field widths fixed by the interface.
  localparam int CYL_W    = 16;
  localparam int TRAVEL_W = 17;
  localparam int DISK_W   = 17;
  localparam int INDEX_W  = 2;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  typedef enum logic [INDEX_W-1:0] {
    CFG_START_CYLINDER = 2'd0,
    CFG_DISK_CYLINDERS = 2'd1,
    CFG_SWEEP_UP       = 2'd2
  } cfg_index_t;

  // Back-end controller states.
  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } back_state_t;

  // One request beat.
  typedef struct packed {
    logic [CYL_W-1:0] request_cylinder;
    logic             batch_end;
  } request_t;

  // One visit beat.
  typedef struct packed {
    logic [CYL_W-1:0]    visit_cylinder;
    logic [TRAVEL_W-1:0] travel_total;
    logic                final_visit;
  } visit_t;

  // Classified entry handed from the front to the back.
  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic             upper;
    logic             last;
  } queue_entry_t;

  // Insert and shift-out commands for one sorted row.
  typedef struct packed {
    logic             ins;
    logic             pop;
    logic [CYL_W-1:0] value;
  } row_ctl_t;

  // Schedule settings seen by the front and the back.
  typedef struct packed {
    logic [CYL_W-1:0] start_cylinder;
    logic [CYL_W-1:0] top_cylinder;
    logic             sweep_up;
  } sched_cfg_t;

endpackage

[design/sds_queue.sv]
// ----------------------------------------------------------------------------
// sds_queue: short queue between the scheduler front and back
// A small first-in first-out buffer of classified entries. The head entry
// is presented combinationally and leaves when pop is high.
// ----------------------------------------------------------------------------
module sds_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sds_pkg::queue_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output sds_pkg::queue_entry_t pop_entry,
  output logic                  empty
);

  localparam int PTR_W  = $clog2(sds_pkg::QUEUE_DEPTH);
  localparam int FILL_W = $clog2(sds_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(sds_pkg::QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(sds_pkg::QUEUE_DEPTH);

  sds_pkg::queue_entry_t slots [sds_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [FILL_W-1:0]     fill;
  logic                  do_push;
  logic                  do_pop;

  assign full      = (fill == FILL_MAX);
  assign empty     = (fill == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("sds_queue: push while full");

endmodule

[design/sds_front.sv]
// ----------------------------------------------------------------------------
// sds_front: request intake and classification
// Saturates each request to the top cylinder, drops requests past the
// batch capacity, tags each entry as at or above the head or below it,
// and adds the end boundary after the last request of a batch.
// ----------------------------------------------------------------------------
module sds_front #(
  parameter int MAX_REQUESTS = sds_pkg::MAX_REQUESTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sds_pkg::sched_cfg_t   cfg,
  input  logic                  request_valid,
  output logic                  request_stall,
  input  sds_pkg::request_t     request,
  output logic                  push,
  output sds_pkg::queue_entry_t push_entry,
  input  logic                  queue_full
);

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

  logic [CNT_W-1:0]             cnt;
  logic [CNT_W-1:0]             cnt_next;
  logic                         pend;
  logic                         pend_next;
  logic                         accept;
  logic                         room;
  logic [sds_pkg::CYL_W-1:0]    sat;
  logic [sds_pkg::CYL_W-1:0]    bnd;
  sds_pkg::queue_entry_t        req_entry;
  sds_pkg::queue_entry_t        bnd_entry;

  assign request_stall = pend || queue_full;
  assign accept        = request_valid && !request_stall;
  assign room          = (cnt < CNT_MAX);

  // Classified request and boundary entries.
  always_comb begin
    sat = (request.request_cylinder > cfg.top_cylinder) ?
          cfg.top_cylinder : request.request_cylinder;
    bnd = cfg.sweep_up ? cfg.top_cylinder : '0;
    req_entry.cylinder = sat;
    req_entry.upper    = (sat >= cfg.start_cylinder);
    req_entry.last     = 1'b0;
    bnd_entry.cylinder = bnd;
    bnd_entry.upper    = (bnd >= cfg.start_cylinder);
    bnd_entry.last     = 1'b1;
  end

  // Push selection and batch bookkeeping.
  always_comb begin
    push       = 1'b0;
    push_entry = req_entry;
    cnt_next   = cnt;
    pend_next  = pend;
    if (pend) begin
      push       = !queue_full;
      push_entry = bnd_entry;
      pend_next  = queue_full;
    end else if (accept) begin
      if (room) begin
        push      = 1'b1;
        cnt_next  = cnt + 1'b1;
        pend_next = request.batch_end;
      end else if (request.batch_end) begin
        push       = 1'b1;
        push_entry = bnd_entry;
      end
      if (request.batch_end) begin
        cnt_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      pend <= pend_next;
    end
  end

  // The stored count never passes the batch capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_MAX)
    else $error("sds_front: request count past capacity");

endmodule

[design/sds_sorted_row.sv]
// ----------------------------------------------------------------------------
// sds_sorted_row: row of cells kept in sorted order
// Each insert places the new value in order, every cell comparing itself
// with it. A pop shifts the row by one toward cell zero, which always
// holds the next value in order.
// ----------------------------------------------------------------------------
module sds_sorted_row #(
  parameter int DEPTH = sds_pkg::MAX_REQUESTS + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         descend,
  input  sds_pkg::row_ctl_t            ctl,
  output logic [sds_pkg::CYL_W-1:0]    head,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [sds_pkg::CYL_W-1:0] cells [DEPTH];
  logic [DEPTH-1:0]          beyond;
  logic [DEPTH-1:0]          take;

  // A cell is beyond the new value when it must move one place up.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      beyond[i] = (CNT_W'(i) < count) &&
                  (descend ? (cells[i] < ctl.value) : (cells[i] > ctl.value));
      take[i]   = (CNT_W'(i) < count) ? beyond[i] : (CNT_W'(i) == count);
    end
  end

  assign head = cells[0];

  // Cell updates.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [sds_pkg::CYL_W-1:0] ins_val;
    logic [sds_pkg::CYL_W-1:0] pop_val;
    if (g == 0) begin : g_first
      assign ins_val = ctl.value;
    end else begin : g_rest
      assign ins_val = beyond[g-1] ? cells[g-1] : ctl.value;
    end
    if (g == DEPTH - 1) begin : g_top
      assign pop_val = cells[g];
    end else begin : g_mid
      assign pop_val = cells[g+1];
    end
    always_ff @(posedge clk) begin
      if (ctl.ins) begin
        if (take[g]) begin
          cells[g] <= ins_val;
        end
      end else if (ctl.pop) begin
        cells[g] <= pop_val;
      end
    end
  end

  // Occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.ins) begin
      count <= count + 1'b1;
    end else if (ctl.pop) begin
      count <= count - 1'b1;
    end
  end

  // The two lowest cells stay in order.
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |->
      (descend ? (cells[0] >= cells[1]) : (cells[0] <= cells[1])))
    else $error("sds_sorted_row: row out of order");

endmodule

[design/sds_back.sv]
// ----------------------------------------------------------------------------
// sds_back: sorted insertion and SCAN visit emission
// Drains the queue into two sorted rows, one for cylinders at or above the
// head in ascending order and one for those below it in descending order.
// After the boundary entry it emits the rows in sweep order with the
// running head travel.
// ----------------------------------------------------------------------------
module sds_back #(
  parameter int MAX_REQUESTS = sds_pkg::MAX_REQUESTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sds_pkg::sched_cfg_t               cfg,
  input  sds_pkg::queue_entry_t             q_entry,
  input  logic                              q_empty,
  output logic                              q_pop,
  output sds_pkg::row_ctl_t                 up_ctl,
  output sds_pkg::row_ctl_t                 lo_ctl,
  input  logic [sds_pkg::CYL_W-1:0]         up_head,
  input  logic [sds_pkg::CYL_W-1:0]         lo_head,
  input  logic [$clog2(MAX_REQUESTS+2)-1:0] up_cnt,
  input  logic [$clog2(MAX_REQUESTS+2)-1:0] lo_cnt,
  output logic                              visit_valid,
  input  logic                              visit_stall,
  output sds_pkg::visit_t                   visit
);

  localparam int CNT_W = $clog2(MAX_REQUESTS + 2);

  sds_pkg::back_state_t         state;
  sds_pkg::back_state_t         state_next;
  logic [sds_pkg::CYL_W-1:0]    head_pos;
  logic [sds_pkg::TRAVEL_W-1:0] travel;
  logic [sds_pkg::CYL_W-1:0]    pick;
  logic [sds_pkg::CYL_W-1:0]    step_len;
  logic [sds_pkg::TRAVEL_W-1:0] travel_next;
  logic                         adv;
  logic                         sel_up;
  logic                         last_one;
  logic                         start_emit;

  // Next row to serve and the travel it adds.
  always_comb begin
    sel_up   = cfg.sweep_up ? (up_cnt != '0) : (lo_cnt == '0);
    pick     = sel_up ? up_head : lo_head;
    last_one = ((up_cnt == CNT_W'(1)) && (lo_cnt == '0)) ||
               ((up_cnt == '0) && (lo_cnt == CNT_W'(1)));
    step_len    = (pick > head_pos) ? (pick - head_pos) : (head_pos - pick);
    travel_next = travel + {1'b0, step_len};
  end

  // Controller: next state and row commands.
  always_comb begin
    state_next   = state;
    q_pop        = 1'b0;
    adv          = 1'b0;
    start_emit   = 1'b0;
    up_ctl.value = q_entry.cylinder;
    lo_ctl.value = q_entry.cylinder;
    case (state)
      sds_pkg::ST_LOAD: begin
        q_pop = !q_empty;
        if (q_pop && q_entry.last) begin
          start_emit = 1'b1;
          state_next = sds_pkg::ST_EMIT;
        end
      end
      sds_pkg::ST_EMIT: begin
        adv = !visit_valid || !visit_stall;
        if (adv && last_one) begin
          state_next = sds_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = sds_pkg::ST_LOAD;
      end
    endcase
    up_ctl.ins = q_pop && q_entry.upper;
    lo_ctl.ins = q_pop && !q_entry.upper;
    up_ctl.pop = adv && sel_up;
    lo_ctl.pop = adv && !sel_up;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sds_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Head position and travel accumulator.
  always_ff @(posedge clk) begin
    if (start_emit) begin
      head_pos <= cfg.start_cylinder;
      travel   <= '0;
    end else if (adv) begin
      head_pos <= pick;
      travel   <= travel_next;
    end
  end

  // Output register for visit beats.
  always_ff @(posedge clk) begin
    if (rst) begin
      visit_valid <= 1'b0;
    end else if (adv) begin
      visit_valid <= 1'b1;
    end else if (!visit_stall) begin
      visit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      visit.visit_cylinder <= pick;
      visit.travel_total   <= travel_next;
      visit.final_visit    <= last_one;
    end
  end

  // Emission always has at least one stored entry to serve.
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == sds_pkg::ST_EMIT) |-> ((up_cnt != '0) || (lo_cnt != '0)))
    else $error("sds_back: emitting with both rows empty");

  // Travel only grows within a schedule.
  a_travel_grows: assert property (@(posedge clk) disable iff (rst)
    adv |=> (travel >= $past(travel)))
    else $error("sds_back: travel total went down");

endmodule

[design/scan_disk_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// scan_disk_scheduler_unit: SCAN elevator disk scheduler
// Collects a batch of cylinder requests and returns the SCAN service order,
// with the running head travel on each visit and the last visit marked.
//
//   Channel   Direction  Handshake                  Beat
//   request   in         request_valid/stall        request_t
//   visit     out        visit_valid/stall          visit_t
//   config    in         write_enable               reg_index, write_data
//
// The end boundary follows the last request of a batch into the queue.
// While loading, the back inserts one queued entry a cycle into its rows
// whenever the queue holds one; for a batch of n requests within capacity
// it then emits n + 1 visits at one a cycle while the visit side does not
// stall, set by the shift-out of the sorted rows. Reset is synchronous and
// clears all control state; the rows need no clearing. A stall on the visit
// side holds the back, while the queue keeps taking requests until it fills.
// ----------------------------------------------------------------------------
module scan_disk_scheduler_unit #(
  parameter int MAX_REQUESTS = sds_pkg::MAX_REQUESTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         write_enable,
  input  logic [sds_pkg::INDEX_W-1:0]  reg_index,
  input  logic [sds_pkg::DISK_W-1:0]   write_data,
  input  logic                         request_valid,
  output logic                         request_stall,
  input  sds_pkg::request_t            request,
  output logic                         visit_valid,
  input  logic                         visit_stall,
  output sds_pkg::visit_t              visit
);

  localparam int ROW_DEPTH = MAX_REQUESTS + 1;
  localparam int ROW_CNT_W = $clog2(ROW_DEPTH + 1);
  localparam logic [sds_pkg::DISK_W-1:0] DISK_FULL =
    sds_pkg::DISK_W'(1 << sds_pkg::CYL_W);

  logic [sds_pkg::CYL_W-1:0]  start_cylinder;
  logic [sds_pkg::DISK_W-1:0] disk_cylinders;
  logic                       sweep_up;
  logic [sds_pkg::DISK_W-1:0] disk_less;
  sds_pkg::sched_cfg_t        cfg;

  logic                       push;
  sds_pkg::queue_entry_t      push_entry;
  logic                       q_full;
  logic                       q_pop;
  sds_pkg::queue_entry_t      q_entry;
  logic                       q_empty;

  sds_pkg::row_ctl_t          up_ctl;
  sds_pkg::row_ctl_t          lo_ctl;
  logic [sds_pkg::CYL_W-1:0]  up_head;
  logic [sds_pkg::CYL_W-1:0]  lo_head;
  logic [ROW_CNT_W-1:0]       up_cnt;
  logic [ROW_CNT_W-1:0]       lo_cnt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_cylinder <= '0;
      disk_cylinders <= DISK_FULL;
      sweep_up       <= 1'b1;
    end else if (write_enable) begin
      case (reg_index)
        sds_pkg::CFG_START_CYLINDER: start_cylinder <= write_data[sds_pkg::CYL_W-1:0];
        sds_pkg::CFG_DISK_CYLINDERS: disk_cylinders <= write_data;
        sds_pkg::CFG_SWEEP_UP:       sweep_up       <= write_data[0];
        default: begin
        end
      endcase
    end
  end

  // Top cylinder: zero cylinders counts as one, large counts saturate.
  always_comb begin
    disk_less          = disk_cylinders - 1'b1;
    cfg.start_cylinder = start_cylinder;
    cfg.sweep_up       = sweep_up;
    if (disk_cylinders == '0) begin
      cfg.top_cylinder = '0;
    end else if (disk_cylinders > DISK_FULL) begin
      cfg.top_cylinder = '1;
    end else begin
      cfg.top_cylinder = disk_less[sds_pkg::CYL_W-1:0];
    end
  end

  sds_front #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .push          (push),
    .push_entry    (push_entry),
    .queue_full    (q_full)
  );

  sds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_entry),
    .empty      (q_empty)
  );

  // Ascending row for cylinders at or above the head.
  sds_sorted_row #(
    .DEPTH (ROW_DEPTH)
  ) u_up_row (
    .clk     (clk),
    .rst     (rst),
    .descend (1'b0),
    .ctl     (up_ctl),
    .head    (up_head),
    .count   (up_cnt)
  );

  // Descending row for cylinders below the head.
  sds_sorted_row #(
    .DEPTH (ROW_DEPTH)
  ) u_lo_row (
    .clk     (clk),
    .rst     (rst),
    .descend (1'b1),
    .ctl     (lo_ctl),
    .head    (lo_head),
    .count   (lo_cnt)
  );

  sds_back #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_entry     (q_entry),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .up_ctl      (up_ctl),
    .lo_ctl      (lo_ctl),
    .up_head     (up_head),
    .lo_head     (lo_head),
    .up_cnt      (up_cnt),
    .lo_cnt      (lo_cnt),
    .visit_valid (visit_valid),
    .visit_stall (visit_stall),
    .visit       (visit)
  );

endmodule
